// ===== design/ils_pkg.sv =====
// Shared types and constants of the indexed list store.
package ils_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 11;

  // Word returned by a read that fails.
  localparam logic signed [ValueW-1:0] ReadFail = '1;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

endpackage

// ===== design/ils_ram.sv =====
// Simple dual-port entry memory with one write port and a registered read port.
module ils_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic signed [ils_pkg::ValueW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic signed [ils_pkg::ValueW-1:0] rdata_o
);
  import ils_pkg::*;

  logic signed [ValueW-1:0] mem_q [Depth];
  logic signed [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/indexed_list_store.sv =====
// Top level of the indexed list store: operation sequencer, count and result registers.
// Results: append, write, a tail remove and any failed operation give their result
// registered at the accepting edge; a read goes through S_READ, other removes through S_SHIFT.
// Throughput: one item per cycle for append and write; a read holds busy in S_READ, a remove
// while later entries move down one place per cycle through the single memory port pair.
// Reset clears the count and the sequencer at once; entry contents stay undefined until written.
// The receiver cannot stall: each result beat is shown on done_o for exactly one cycle.
module indexed_list_store #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [ils_pkg::OpW-1:0]            op_i,
  input  logic [ils_pkg::IndexW-1:0]         index_i,
  input  logic signed [ils_pkg::ValueW-1:0]  value_i,
  output logic                               done_o,
  output logic signed [ils_pkg::ValueW-1:0]  read_value_o,
  output logic [ils_pkg::StatusW-1:0]        status_o,
  output logic [ils_pkg::CountW-1:0]         count_o
);
  import ils_pkg::*;

  // Address width of the memory, width of the entry count (which can reach DEPTH itself),
  // and a compare width wide enough for both the index field plus one and the count.
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = ((CW > IndexW) ? CW : IndexW) + 1;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic                  done_q, done_d;
  logic signed [ValueW-1:0] rv_q, rv_d;
  status_e               st_q, st_d;

  // Memory port controls.
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic signed [ValueW-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic signed [ValueW-1:0] mem_rdata;

  // Decode helpers for the incoming beat.
  logic [XW-1:0]         xidx, xidx_nxt, xcnt;
  logic                  in_range, is_last, full;
  logic [CW-1:0]         ptr_nxt;

  assign xidx     = XW'(index_i);
  assign xidx_nxt = xidx + 1'b1;
  assign xcnt     = XW'(count_q);
  assign in_range = xidx < xcnt;
  assign is_last  = xidx_nxt == xcnt;
  assign full     = count_q == CW'(DEPTH);
  assign ptr_nxt  = ptr_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    done_d    = 1'b0;
    rv_d      = '0;
    st_d      = ST_OK;
    mem_we    = 1'b0;
    mem_waddr = count_q[AW-1:0];
    mem_wdata = value_i;
    mem_re    = 1'b0;
    mem_raddr = xidx[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (op_e'(op_i))
            OP_APPEND: begin
              done_d = 1'b1;
              if (full) begin
                st_d = ST_FULL;
              end else begin
                // The count is below DEPTH here, so it is a valid address.
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            OP_READ: begin
              if (!in_range) begin
                done_d = 1'b1;
                rv_d   = ReadFail;
                st_d   = ST_RANGE;
              end else begin
                mem_re  = 1'b1;
                state_d = S_READ;
              end
            end
            OP_WRITE: begin
              done_d = 1'b1;
              if (!in_range) begin
                st_d = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = xidx[AW-1:0];
              end
            end
            OP_REMOVE: begin
              if (!in_range) begin
                done_d = 1'b1;
                st_d   = ST_RANGE;
              end else if (is_last) begin
                // Removing the tail entry needs no move.
                done_d  = 1'b1;
                count_d = count_q - 1'b1;
              end else begin
                // Fetch the first entry that moves down; the gap is at the index.
                mem_re    = 1'b1;
                mem_raddr = xidx_nxt[AW-1:0];
                ptr_d     = xidx_nxt[CW-1:0];
                state_d   = S_SHIFT;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_READ: begin
        done_d  = 1'b1;
        rv_d    = mem_rdata;
        state_d = S_IDLE;
      end

      S_SHIFT: begin
        // The entry read last cycle from ptr lands one place lower, while the next one is
        // fetched. Reads run ahead of writes, so the two never touch the same entry.
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AW-1:0] - 1'b1;
        mem_wdata = mem_rdata;
        if (ptr_nxt < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_nxt[AW-1:0];
          ptr_d     = ptr_nxt;
        end else begin
          done_d  = 1'b1;
          count_d = count_q - 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Result payload and the shift pointer carry no reset.
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    rv_q  <= rv_d;
    st_q  <= st_d;
  end

  ils_ram #(
    .Depth (DEPTH),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // A new beat is taken only in the idle state.
  assign busy         = state_q != S_IDLE;
  assign done_o       = done_q;
  assign read_value_o = rv_q;
  assign status_o     = st_q;
  assign count_o      = CountW'(count_q);

endmodule

// ===== design/ils_checker.sv =====
// Port-level assertions for the indexed list store and their bind.
module ils_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic [ils_pkg::OpW-1:0]            op_i,
  input logic                               done_o,
  input logic [ils_pkg::StatusW-1:0]        status_o,
  input logic [ils_pkg::CountW-1:0]         count_o
);
  import ils_pkg::*;

  // An accepted append always answers in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OP_APPEND) |=> done_o)
    else $error("append beat gave no result in the next cycle");

  // A result beat is only shown once the sequencer is back to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat shown while busy");

  // The count only moves together with a successful result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_o) |-> (done_o && status_o == ST_OK))
    else $error("count changed without a successful result beat");

  // A dropped append leaves the count as it was.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> $stable(count_o))
    else $error("full append changed the count");

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);

// ===== bench/indexed_list_store_tb.sv =====
// Self-checking testbench for the indexed list store with directed and random operation traffic.
module indexed_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  // The store is built at its full size so that the full-store case is reached with real
  // 10-bit indexes.
  localparam int unsigned StoreDepth = 1024;

  // Mismatches past this many are only counted, not printed.
  localparam int unsigned ReportLimit = 10;

  // Longest wait for outstanding results at the end of the run. A remove at index 0 of a
  // full store moves 1023 entries, so this leaves plenty of room.
  localparam int unsigned DrainLimit = 4096;

  // One result beat as the block should show it.
  typedef struct {
    logic signed [ValueW-1:0] read_value;
    status_e                  status;
    logic [CountW-1:0]        count;
  } list_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [OpW-1:0]           op_i = OP_APPEND;
  logic [IndexW-1:0]        index_i = '0;
  logic signed [ValueW-1:0] value_i = '0;
  logic                     done_o;
  logic signed [ValueW-1:0] read_value_o;
  logic [StatusW-1:0]       status_o;
  logic [CountW-1:0]        count_o;

  // Shadow copy of the list contents and the count, kept in step with every accepted beat.
  logic signed [ValueW-1:0] shadow_words [StoreDepth];
  int unsigned              shadow_count = 0;

  // Results still owed by the block, oldest first.
  list_result_t pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned result_beats = 0;

  // Chance, in percent, that the sender leaves a cycle empty before its next beat.
  int unsigned sender_idle_pct = 0;

  indexed_list_store #(
    .DEPTH(StoreDepth)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one operation to the shadow list and returns the result it must produce.
  // Any index at or past the count is out of range for a read, write or remove; only an append
  // can hit the full store, and a failed operation leaves the list untouched.
  function automatic list_result_t apply_list_op(op_e op, logic [IndexW-1:0] idx,
                                                 logic signed [ValueW-1:0] val);
    list_result_t res;
    res.read_value = '0;
    res.status     = ST_OK;
    if (op == OP_APPEND) begin
      if (shadow_count >= StoreDepth) begin
        res.status = ST_FULL;
      end else begin
        shadow_words[shadow_count] = val;
        shadow_count++;
      end
    end else if (idx >= shadow_count) begin
      res.status = ST_RANGE;
      if (op == OP_READ) begin
        res.read_value = ReadFail;
      end
    end else begin
      case (op)
        OP_READ: begin
          res.read_value = shadow_words[idx];
        end
        OP_WRITE: begin
          shadow_words[idx] = val;
        end
        OP_REMOVE: begin
          // Close the gap: every later entry moves down one place.
          for (int unsigned i = idx; i + 1 < shadow_count; i++) begin
            shadow_words[i] = shadow_words[i + 1];
          end
          shadow_count--;
        end
        default: ;
      endcase
    end
    res.count = shadow_count[CountW-1:0];
    return res;
  endfunction

  function automatic void note_mismatch(string msg);
    if (mismatch_count < ReportLimit) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
    mismatch_count++;
  endfunction

  // Sends one beat. The sender may first sit idle with start low; then the fields are
  // presented with start high until an edge sees busy low, which is the edge that accepts
  // the beat. Start is left high on return so that a following beat can go out back to
  // back without start being lowered and raised in the same step.
  task automatic issue_op(op_e op, logic [IndexW-1:0] idx, logic signed [ValueW-1:0] val);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    op_i    <= op;
    index_i <= idx;
    value_i <= val;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    // Predicting at the accepting edge keeps the expectations in acceptance order.
    pending_results.push_back(apply_list_op(op, idx, val));
  endtask

  // Every result beat is taken at the edge that ends its cycle; busy and the outputs are
  // read before the block's own updates for that edge land, so the check is race free.
  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      result_beats++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf(
          "beat %0d arrived with nothing expected: read_value %0d status %0d count %0d",
          result_beats, read_value_o, status_o, count_o));
      end else begin
        want = pending_results.pop_front();
        if (read_value_o !== want.read_value || status_o !== want.status ||
            count_o !== want.count) begin
          note_mismatch($sformatf(
            "beat %0d: expected read_value %0d status %0d count %0d, got %0d %0d %0d",
            result_beats, want.read_value, want.status, want.count,
            read_value_o, status_o, count_o));
        end
      end
    end
  end

  // Reads, writes and removes on an empty list must fail their index check; reads and
  // removes are tried at both ends of the index range.
  task automatic test_empty_store();
    issue_op(OP_READ, '0, '0);
    issue_op(OP_WRITE, '0, 32'sh1234_5678);
    issue_op(OP_REMOVE, '0, '0);
    issue_op(OP_READ, '1, '0);
    issue_op(OP_REMOVE, '1, '0);
  endtask

  // Extreme words go in and come back out; then the index equal to the count, writes,
  // and removes at the middle, the end and the front of the list.
  task automatic test_edge_values();
    issue_op(OP_APPEND, '0, 32'sh8000_0000);
    issue_op(OP_APPEND, '1, 32'sh7FFF_FFFF);
    issue_op(OP_APPEND, '0, '0);
    issue_op(OP_APPEND, '0, '1);
    issue_op(OP_APPEND, '0, 32'sh5555_5555);
    issue_op(OP_APPEND, '0, 32'shAAAA_AAAA);
    for (int unsigned i = 0; i < 6; i++) begin
      issue_op(OP_READ, IndexW'(i), '0);
    end
    // The count itself is the first index that is out of range.
    issue_op(OP_READ, IndexW'(6), '0);
    issue_op(OP_READ, '1, '0);
    issue_op(OP_WRITE, IndexW'(5), 32'sh0000_0001);
    issue_op(OP_WRITE, IndexW'(6), 32'sh0BAD_F00D);
    issue_op(OP_REMOVE, IndexW'(6), '0);
    issue_op(OP_REMOVE, IndexW'(2), '0);
    issue_op(OP_REMOVE, IndexW'(4), '0);
    issue_op(OP_REMOVE, '0, '0);
    for (int unsigned i = 0; i < 4; i++) begin
      issue_op(OP_READ, IndexW'(i), '0);
    end
  endtask

  // Fills the store to capacity, so appends are dropped and the top index bits are used,
  // removes at the front to force the longest shift, and then takes a stretch of entries
  // off the tail, reading the front now and then to confirm the shifted contents.
  task automatic test_full_store();
    while (shadow_count < StoreDepth) begin
      issue_op(OP_APPEND, IndexW'($urandom()), $urandom());
    end
    issue_op(OP_APPEND, '0, 32'sh7FFF_FFFF);
    issue_op(OP_APPEND, '1, 32'sh8000_0000);
    issue_op(OP_READ, '1, '0);
    issue_op(OP_READ, IndexW'(512), '0);
    issue_op(OP_WRITE, '1, 32'sh7FFF_FFFF);
    issue_op(OP_READ, '1, '0);
    issue_op(OP_REMOVE, '0, '0);
    issue_op(OP_READ, IndexW'(StoreDepth - 2), '0);
    issue_op(OP_READ, '1, '0);
    issue_op(OP_APPEND, '0, '1);
    issue_op(OP_APPEND, '0, '0);
    issue_op(OP_REMOVE, '1, '0);
    while (shadow_count > StoreDepth - 64) begin
      if (shadow_count % 16 == 0) begin
        issue_op(OP_READ, '0, '0);
      end
      issue_op(OP_REMOVE, IndexW'(shadow_count - 1), $urandom());
    end
  endtask

  // Random mix of all four operations on the long list that the full-store test leaves
  // behind, so removes at random places shift long runs of entries. Appends are favored
  // while the list is short. Most indexes land inside the list; the rest are the boundary
  // index or any 10-bit value, which trips the range check whenever it lands at or above
  // the count.
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned beats);
    op_e                      op;
    logic [IndexW-1:0]        idx;
    logic signed [ValueW-1:0] val;
    int unsigned              roll;
    sender_idle_pct = idle_pct;
    for (int unsigned n = 0; n < beats; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < ((shadow_count < 32) ? 35 : 20)) begin
        op = OP_APPEND;
      end else if (roll < 55) begin
        op = OP_READ;
      end else if (roll < 75) begin
        op = OP_WRITE;
      end else begin
        op = OP_REMOVE;
      end

      roll = $urandom_range(0, 9);
      if (shadow_count > 0 && roll < 8) begin
        idx = IndexW'($urandom_range(0, shadow_count - 1));
      end else if (roll == 8) begin
        idx = IndexW'(shadow_count);
      end else begin
        idx = IndexW'($urandom_range(0, StoreDepth - 1));
      end

      case ($urandom_range(0, 7))
        0:       val = 32'sh8000_0000;
        1:       val = 32'sh7FFF_FFFF;
        2:       val = '1;
        3:       val = '0;
        default: val = $urandom();
      endcase

      issue_op(op, idx, val);
    end
  endtask

  initial begin : main_sequence
    int unsigned drain_cycles;
    drain_cycles = 0;

    // Reset is held from time zero and released at an edge, once for the whole run.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 17;
    test_empty_store();
    test_edge_values();
    test_full_store();

    // Light sender gaps, then heavy gaps, then a stretch with none at all.
    test_random_traffic(17, 175);
    test_random_traffic(53, 175);
    test_random_traffic(0, 175);

    start <= 1'b0;
    while (pending_results.size() != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    // Further edges follow so that a stray extra beat would still be caught.
    repeat (4) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      note_mismatch($sformatf("%0d expected results never arrived",
                              pending_results.size()));
    end

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Safety net against a hung handshake; a correct run ends far sooner, even if every
  // beat were a remove that shifts the whole store.
  initial begin : watchdog
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== indexed_list_store.f =====
design/ils_pkg.sv
design/ils_ram.sv
design/indexed_list_store.sv
design/ils_checker.sv
bench/indexed_list_store_tb.sv
